[sv/ffba_pkg.sv]
// Package with shared constants, types and codes for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned OfsW         = 32;
  localparam int unsigned LenW         = OfsW + 1;
  localparam int unsigned AlignBits    = 3;
  localparam int unsigned EntW         = OfsW + LenW;

  // Command codes.
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Status codes.
  localparam logic [2:0] StGranted = 3'd0;
  localparam logic [2:0] StNoMem   = 3'd1;
  localparam logic [2:0] StZero    = 3'd2;
  localparam logic [2:0] StFreed   = 3'd3;
  localparam logic [2:0] StIgnored = 3'd4;

  // One table entry: start and length.
  typedef struct packed {
    logic [OfsW-1:0] start;
    logic [LenW-1:0] length;
  } entry_t;

endpackage

[sv/ffba_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write at the address; read the old contents into a register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[sv/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: sequencer, tables and shared compare unit.
// A zero request or a null free goes straight to the result; a scan reads the table entries
// one after another, and a free that finds its block scans both tables.
// No input is taken while an item is worked or its result waits, so the next item is taken
// only after the last result is transferred; one RAM port per table sets the scan rate.
// Reset (async, active low) leaves the free table with one entry covering the whole pool.
`timescale 1ns / 1ps
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: request_bytes[31:0], block_offset[63:32].
  input  logic [63:0] s_axis_tdata,
  // tuser: cmd[0], block_is_null[1].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: grant_offset[31:0], status[34:32], zero fill to 40 bits.
  output logic [39:0] m_axis_tdata
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_FRD    = 11'b00000000010,
    S_FCHK   = 11'b00000000100,
    S_FLAST  = 11'b00000001000,
    S_FMOVE  = 11'b00000010000,
    S_URD    = 11'b00000100000,
    S_UCHK   = 11'b00001000000,
    S_ULAST  = 11'b00010000000,
    S_UMOVE  = 11'b00100000000,
    S_MRD    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e          state_q, state_d;
  logic            cmd_q, cmd_d;
  logic [OfsW-1:0] ofs_q, ofs_d;
  logic [LenW-1:0] need_q, need_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] hole_q, hole_d;
  logic [IdxW-1:0] uidx_q, uidx_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic [CntW-1:0] ucnt_q, ucnt_d;
  logic            f0_valid_q, f0_valid_d;
  logic [OfsW-1:0] res_ofs_q, res_ofs_d;
  logic [2:0]      res_st_q, res_st_d;

  logic            fwe, uwe;
  logic [IdxW-1:0] faddr, uaddr;
  entry_t          fwdata, uwdata, frd_raw, frd, urd;

  ffba_ram #(.Width(EntW), .Depth(TableEntries)) u_free_ram (
    .clk_i, .we_i(fwe), .addr_i(faddr), .wdata_i(fwdata), .rdata_o(frd_raw)
  );
  ffba_ram #(.Width(EntW), .Depth(TableEntries)) u_used_ram (
    .clk_i, .we_i(uwe), .addr_i(uaddr), .wdata_i(uwdata), .rdata_o(urd)
  );

  // Free entry 0 reads as the whole pool until first written.
  logic f0_read_q;
  always_comb begin
    frd = frd_raw;
    if (f0_read_q && !f0_valid_q) begin
      frd.start  = '0;
      frd.length = LenW'(1) << OfsW;
    end
  end

  // Shared compare unit: length against need, or start against key.
  logic [LenW-1:0] cmp_a, cmp_b;
  logic            cmp_ge, cmp_eq;
  assign cmp_ge = cmp_a >= cmp_b;
  assign cmp_eq = cmp_a == cmp_b;
  logic [LenW-1:0] sum_res;
  assign sum_res = len_q + {1'b0, ofs_q};

  logic [OfsW-1:0] req;
  assign req = s_axis_tdata[31:0];

  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'd0, res_st_q, res_ofs_q};

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    ofs_d      = ofs_q;
    need_d     = need_q;
    len_d      = len_q;
    hole_d     = hole_q;
    uidx_d     = uidx_q;
    idx_d      = idx_q;
    fcnt_d     = fcnt_q;
    ucnt_d     = ucnt_q;
    f0_valid_d = f0_valid_q;
    res_ofs_d  = res_ofs_q;
    res_st_d   = res_st_q;
    fwe        = 1'b0;
    uwe        = 1'b0;
    faddr      = idx_q[IdxW-1:0];
    uaddr      = idx_q[IdxW-1:0];
    fwdata     = '0;
    uwdata     = '0;
    cmp_a      = frd.length;
    cmp_b      = need_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d  = s_axis_tuser[0];
          ofs_d  = s_axis_tdata[63:32];
          need_d = ({1'b0, req} + LenW'(7)) & ~LenW'(7);
          idx_d  = '0;
          res_ofs_d = '0;
          if (s_axis_tuser[0] == CmdAlloc) begin
            if (req == '0) begin
              res_st_d = StZero;
              state_d  = S_OUT;
            end else begin
              state_d = S_FRD;
            end
          end else if (s_axis_tuser[1]) begin
            res_st_d = StIgnored;
            state_d  = S_OUT;
          end else begin
            state_d = S_URD;
          end
        end
      end
      // Issue a free-table read or finish the scan.
      S_FRD: begin
        if (idx_q >= fcnt_q) begin
          if (cmd_q == CmdAlloc) begin
            res_st_d = StNoMem;
            state_d  = S_OUT;
          end else begin
            // No neighbor: append if there is room.
            if (fcnt_q < CntW'(TableEntries)) begin
              fwe    = 1'b1;
              faddr  = fcnt_q[IdxW-1:0];
              fwdata = '{start: ofs_q, length: len_q};
              if (fcnt_q == '0) f0_valid_d = 1'b1;
              fcnt_d = fcnt_q + CntW'(1);
            end
            state_d = S_UMOVE;
          end
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (cmd_q == CmdAlloc) begin
          cmp_a = frd.length;
          cmp_b = need_q;
          if (cmp_ge) begin
            res_ofs_d = frd.start;
            res_st_d  = StGranted;
            if (ucnt_q < CntW'(TableEntries)) begin
              uwe    = 1'b1;
              uaddr  = ucnt_q[IdxW-1:0];
              uwdata = '{start: frd.start, length: need_q};
              ucnt_d = ucnt_q + CntW'(1);
            end
            hole_d = idx_q[IdxW-1:0];
            if (cmp_eq) begin
              fcnt_d  = fcnt_q - CntW'(1);
              state_d = S_FLAST;
            end else begin
              fwe    = 1'b1;
              faddr  = idx_q[IdxW-1:0];
              fwdata = '{start: frd.start + need_q[OfsW-1:0], length: frd.length - need_q};
              if (idx_q == '0) f0_valid_d = 1'b1;
              state_d = S_OUT;
            end
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_FRD;
          end
        end else begin
          // The end of the block may lie one past the pool, so compare all bits.
          cmp_a = {1'b0, frd.start};
          cmp_b = sum_res;
          if (cmp_eq) begin
            fwe    = 1'b1;
            faddr  = idx_q[IdxW-1:0];
            fwdata = '{start: ofs_q, length: frd.length + len_q};
            if (idx_q == '0) f0_valid_d = 1'b1;
            state_d = S_UMOVE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_FRD;
          end
        end
      end
      // Read the last free entry to fill the hole.
      S_FLAST: begin
        faddr   = fcnt_q[IdxW-1:0];
        state_d = S_FMOVE;
      end
      S_FMOVE: begin
        fwe    = 1'b1;
        faddr  = hole_q;
        fwdata = frd;
        if (hole_q == '0) f0_valid_d = 1'b1;
        state_d = S_OUT;
      end
      // Used-table lookup of the freed offset.
      S_URD: begin
        if (idx_q >= ucnt_q) begin
          res_st_d = StIgnored;
          state_d  = S_OUT;
        end else begin
          state_d = S_UCHK;
        end
      end
      S_UCHK: begin
        cmp_a = {1'b0, urd.start};
        cmp_b = {1'b0, ofs_q};
        if (cmp_eq) begin
          len_d   = urd.length;
          uidx_d  = idx_q[IdxW-1:0];
          idx_d   = '0;
          state_d = S_MRD;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_URD;
        end
      end
      // A wait state after the length register is loaded, before the free scan uses the sum.
      S_MRD: begin
        state_d = S_FRD;
      end
      S_UMOVE: begin
        ucnt_d  = ucnt_q - CntW'(1);
        uaddr   = ucnt_d[IdxW-1:0];
        state_d = S_ULAST;
      end
      S_ULAST: begin
        uwe      = 1'b1;
        uaddr    = uidx_q;
        uwdata   = urd;
        res_st_d = StFreed;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Entry 0 override applies to reads issued at address zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_read_q <= 1'b0;
    end else begin
      f0_read_q <= (faddr == '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fcnt_q     <= CntW'(1);
      ucnt_q     <= '0;
      f0_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fcnt_q     <= fcnt_d;
      ucnt_q     <= ucnt_d;
      f0_valid_q <= f0_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    ofs_q     <= ofs_d;
    need_q    <= need_d;
    len_q     <= len_d;
    hole_q    <= hole_d;
    uidx_q    <= uidx_d;
    idx_q     <= idx_d;
    res_ofs_q <= res_ofs_d;
    res_st_q  <= res_st_d;
  end

endmodule

[sv/ffba_checker.sv]
// Port checker for the first-fit block allocator, bound to the top level.
`timescale 1ns / 1ps
module ffba_checker
  import ffba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A result stays offered until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // Input is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // Only a grant carries a nonzero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[34:32] != StGranted) |-> (m_axis_tdata[31:0] == '0))
    else $error("offset without grant");

  // Status codes stay within the defined range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34:32] <= StIgnored))
    else $error("bad status");

  // After an input transfer, no new input is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back input transfer");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[tb/sv/tb_first_fit_block_allocator.sv]
// Testbench for the first-fit block allocator: directed and random streams checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
  import ffba_pkg::*;

  typedef struct {
    logic            cmd;
    logic [OfsW-1:0] req;
    logic [OfsW-1:0] ofs;
    logic            nul;
  } op_t;

  typedef struct {
    logic [OfsW-1:0] ofs;
    logic [2:0]      st;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;

  op_t             pend_ops[$];
  grant_t          want_q[$];
  logic [OfsW-1:0] live_blocks[$];
  op_t             cur_op;
  int              snd_idle = 34;
  int              rcv_idle = 79;
  int              err_cnt = 0;
  bit              hold_go = 1'b0;
  bit              hold_used = 1'b0;
  int              hold_left = 0;

  // Predictor copy of both tables.
  logic [OfsW-1:0] pf_start[TableEntries];
  logic [LenW-1:0] pf_len[TableEntries];
  int              pf_cnt;
  logic [OfsW-1:0] pu_start[TableEntries];
  logic [LenW-1:0] pu_len[TableEntries];
  int              pu_cnt;

  first_fit_block_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always #5 clk_i = ~clk_i;

  // Works out the result of one operation and updates the predicted tables.
  function automatic grant_t alloc_outcome(op_t op);
    grant_t          r;
    logic [LenW-1:0] need;
    logic [LenW-1:0] rest;
    logic [LenW-1:0] nxt;
    logic [LenW-1:0] blen;
    logic [OfsW-1:0] base;
    int              u;
    int              f;
    bit              hit;
    r.ofs = '0;
    if (op.cmd == CmdAlloc) begin
      if (op.req == '0) begin
        r.st = StZero;
        return r;
      end
      need = ({1'b0, op.req} + 33'd7) & ~33'd7;
      for (int i = 0; i < pf_cnt; i++) begin
        if (pf_len[i] >= need) begin
          base = pf_start[i];
          rest = pf_len[i] - need;
          if (pu_cnt < TableEntries) begin
            pu_start[pu_cnt] = base;
            pu_len[pu_cnt] = need;
            pu_cnt++;
          end
          if (rest == '0) begin
            pf_cnt--;
            pf_start[i] = pf_start[pf_cnt];
            pf_len[i] = pf_len[pf_cnt];
          end else begin
            pf_start[i] = base + need[OfsW-1:0];
            pf_len[i] = rest;
          end
          r.ofs = base;
          r.st = StGranted;
          return r;
        end
      end
      r.st = StNoMem;
      return r;
    end
    r.st = StIgnored;
    if (op.nul) return r;
    hit = 1'b0;
    u = 0;
    for (int i = 0; i < pu_cnt && !hit; i++) begin
      if (pu_start[i] == op.ofs) begin
        hit = 1'b1;
        u = i;
      end
    end
    if (!hit) return r;
    blen = pu_len[u];
    nxt = {1'b0, op.ofs} + blen;
    hit = 1'b0;
    f = 0;
    for (int i = 0; i < pf_cnt && !hit; i++) begin
      if ({1'b0, pf_start[i]} == nxt) begin
        hit = 1'b1;
        f = i;
      end
    end
    if (hit) begin
      pf_start[f] = op.ofs;
      pf_len[f] = pf_len[f] + blen;
    end else if (pf_cnt < TableEntries) begin
      pf_start[pf_cnt] = op.ofs;
      pf_len[pf_cnt] = blen;
      pf_cnt++;
    end
    pu_cnt--;
    pu_start[u] = pu_start[pu_cnt];
    pu_len[u] = pu_len[pu_cnt];
    r.st = StFreed;
    return r;
  endfunction

  // Driver: predicts each accepted transfer and presents the next pending one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) want_q = {want_q, alloc_outcome(cur_op)};
      if (!s_valid || s_ready) begin
        if (pend_ops.size() > 0 && $urandom_range(99) >= snd_idle) begin
          cur_op = pend_ops.pop_front();
          s_valid <= 1'b1;
          s_data <= {cur_op.ofs, cur_op.req};
          s_user <= {cur_op.nul, cur_op.cmd};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
      m_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    grant_t w;
    if (rst_ni && m_valid && m_ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result: grant_offset %h status %0d", m_data[31:0], m_data[34:32]);
        err_cnt++;
      end else begin
        w = want_q.pop_front();
        if (m_data[31:0] !== w.ofs) begin
          $error("grant_offset: expected %h, actual %h", w.ofs, m_data[31:0]);
          err_cnt++;
        end
        if (m_data[34:32] !== w.st) begin
          $error("status: expected %0d, actual %0d", w.st, m_data[34:32]);
          err_cnt++;
        end
        if (w.st == StGranted) live_blocks = {live_blocks, w.ofs};
      end
    end
  end

  task automatic queue_op(logic cmd, logic [OfsW-1:0] req, logic [OfsW-1:0] ofs, logic nul);
    op_t op;
    op.cmd = cmd;
    op.req = req;
    op.ofs = ofs;
    op.nul = nul;
    pend_ops = {pend_ops, op};
  endtask

  task automatic queue_alloc(logic [OfsW-1:0] req);
    queue_op(CmdAlloc, req, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic queue_free(logic [OfsW-1:0] ofs);
    queue_op(CmdFree, $urandom, ofs, 1'b0);
  endtask

  // Frees a randomly chosen live block, or a random offset when none is left.
  task automatic queue_free_live();
    int k;
    if (live_blocks.size() == 0) begin
      queue_free($urandom);
    end else begin
      k = $urandom_range(live_blocks.size() - 1);
      queue_free(live_blocks[k]);
      live_blocks.delete(k);
    end
  endtask

  task automatic wait_idle();
    while (pend_ops.size() > 0 || s_valid || want_q.size() > 0) @(posedge clk_i);
  endtask

  // Timeout guard.
  initial begin
    #(200_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    logic [OfsW-1:0] x_ofs;
    for (int i = 0; i < TableEntries; i++) begin
      pf_start[i] = '0;
      pf_len[i] = '0;
      pu_start[i] = '0;
      pu_len[i] = '0;
    end
    pf_len[0] = 33'h1_0000_0000;
    pf_cnt = 1;
    pu_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: exact fits, empty free table, null and unknown frees, merges.
    queue_alloc(32'h0);
    queue_alloc(32'hFFFF_FFFF);
    queue_alloc(32'h8);
    queue_op(CmdFree, 32'hFFFF_FFFF, 32'h0, 1'b1);
    queue_free(32'hFFFF_FFFF);
    queue_free(32'h0);
    queue_alloc(32'h1);
    queue_alloc(32'h8);
    queue_alloc(32'hFFFF_FFF0);
    queue_alloc(32'h8);
    queue_free(32'h8);
    queue_free(32'h0);
    queue_alloc(32'h10);
    queue_free(32'h10);
    queue_free(32'h0);
    queue_alloc(32'h7);
    queue_op(CmdFree, 32'h0, 32'hFFFF_FFFF, 1'b1);
    wait_idle();
    live_blocks.delete();
    queue_free(32'h0);
    wait_idle();

    // Random mix of allocations and frees.
    for (int b = 0; b < 4; b++) begin
      if (b == 2) begin
        snd_idle = 79;
        rcv_idle = 34;
      end
      for (int n = 0; n < 40; n++) begin
        r = $urandom_range(99);
        if (r < 35) queue_alloc($urandom_range(256, 1));
        else if (r < 45) queue_alloc($urandom_range(1 << 20, 1));
        else if (r < 50) queue_alloc($urandom);
        else if (r < 85) queue_free_live();
        else if (r < 92) queue_free($urandom);
        else if (r < 96) queue_op(CmdFree, $urandom, $urandom, 1'b1);
        else queue_alloc(32'h0);
      end
      wait_idle();
    end

    // Fragment the pool until both tables overflow.
    for (int n = 0; n < 258; n++) begin
      queue_alloc($urandom_range(8, 1));
      queue_alloc($urandom_range(64, 1));
      wait_idle();
      x_ofs = live_blocks[live_blocks.size() - 2];
      live_blocks.delete(live_blocks.size() - 2);
      queue_free(x_ofs);
    end
    wait_idle();

    // Release everything with no idling, then allocate again, under one long receiver stall.
    snd_idle = 0;
    rcv_idle = 0;
    hold_go = 1'b1;
    while (live_blocks.size() > 0) queue_free_live();
    for (int n = 0; n < 30; n++) queue_alloc($urandom_range(4096, 1));
    wait_idle();

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/first_fit_block_allocator.sv
sv/ffba_checker.sv
tb/sv/tb_first_fit_block_allocator.sv
